FILE: hw/rtl/pdh_pkg.sv
// ----------------------------------------------------------------------------
// pdh_pkg
// shared widths, codes and defaults of the pair distance histogram block
// ----------------------------------------------------------------------------
package pdh_pkg;

  // default sizing
  localparam int DEF_MAX_ATOMS   = 1024;
  localparam int DEF_MAX_BINS    = 256;
  localparam int DEF_NUM_SPECIES = 8;

  // transaction field widths
  localparam int ACTION_W  = 2;
  localparam int POS_W     = 32;
  localparam int SPECIES_W = 3;
  localparam int BINSEL_W  = 8;
  localparam int CLSSEL_W  = 6;
  localparam int COUNT_W   = 32;
  localparam int ATOMS_W   = 11;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int BOX_W      = 31;
  localparam int BINS_W     = 9;

  localparam logic [BOX_W-1:0]  BIN_WIDTH_RESET = 31'd6554;
  localparam logic [BINS_W-1:0] BINS_RESET      = 9'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PBC_ENABLE  = 3'd0,
    REG_BOX_LEN_X   = 3'd1,
    REG_BOX_LEN_Y   = 3'd2,
    REG_BOX_LEN_Z   = 3'd3,
    REG_BIN_WIDTH   = 3'd4,
    REG_BINS_IN_USE = 3'd5,
    REG_NORM_SCALE  = 3'd6,
    REG_PAIR_MODE   = 3'd7
  } reg_index_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  localparam logic RESULT_RUN  = 1'b0;
  localparam logic RESULT_READ = 1'b1;

endpackage

FILE: hw/rtl/pdh_item_if.sv
// ----------------------------------------------------------------------------
// pdh_item_if
// input channel: load, run and read transactions
// ----------------------------------------------------------------------------
interface pdh_item_if;
  import pdh_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [ACTION_W-1:0]         action;
  logic signed [POS_W-1:0]     pos_x;
  logic signed [POS_W-1:0]     pos_y;
  logic signed [POS_W-1:0]     pos_z;
  logic [SPECIES_W-1:0]        species;
  logic [BINSEL_W-1:0]         bin_select;
  logic [CLSSEL_W-1:0]         class_select;

  modport source (
    output valid, action, pos_x, pos_y, pos_z, species, bin_select, class_select,
    input  ready
  );

  modport sink (
    input  valid, action, pos_x, pos_y, pos_z, species, bin_select, class_select,
    output ready
  );

endinterface

FILE: hw/rtl/pdh_result_if.sv
// ----------------------------------------------------------------------------
// pdh_result_if
// output channel: run completion and bin read answers
// ----------------------------------------------------------------------------
interface pdh_result_if;
  import pdh_pkg::*;

  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [COUNT_W-1:0] bin_pairs;
  logic [COUNT_W-1:0] g_value;
  logic [COUNT_W-1:0] pairs_counted;
  logic [ATOMS_W-1:0] atoms_loaded;
  logic               load_overflow;

  modport source (
    output valid, result_kind, bin_pairs, g_value, pairs_counted, atoms_loaded,
           load_overflow,
    input  ready
  );

  modport sink (
    input  valid, result_kind, bin_pairs, g_value, pairs_counted, atoms_loaded,
           load_overflow,
    output ready
  );

endinterface

FILE: hw/rtl/pdh_ram.sv
// ----------------------------------------------------------------------------
// pdh_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pair_distance_histogram_rdf.sv
// ----------------------------------------------------------------------------
// pair_distance_histogram_rdf
// pair distance histogram (radial distribution function) over stored atoms
// ----------------------------------------------------------------------------
// Load transactions store one atom (signed Q16.16 position and species) per
// cycle into the atom ram while the block is idle; loads are taken back to
// back. A run transaction sweeps the histogram ram to zero (one entry per
// cycle, (classes+1)*MAX_BINS entries, 9472 with defaults) and then walks
// every unordered atom pair i<j. For each pair the atom ram port fetches atom
// j, in periodic mode a bit-serial remainder unit folds each axis into the
// minimum image, one 32x32 multiplier sums the squares one axis at a time, a
// 34-step digit recurrence takes the square root, a BIN_BITS-step divider
// finds the bin, and each bin update is a read/write pair on the histogram
// ram (two pairs in species pair mode). A read transaction normalizes g with
// a 32-step divider. After reset the same clearing pass runs before the first
// transaction is taken. Configuration is written by the user only while the
// block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pair_distance_histogram_rdf #(
  parameter int MAX_ATOMS   = pdh_pkg::DEF_MAX_ATOMS,
  parameter int MAX_BINS    = pdh_pkg::DEF_MAX_BINS,
  parameter int NUM_SPECIES = pdh_pkg::DEF_NUM_SPECIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pdh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdh_pkg::CFG_DATA_W-1:0]  cfg_data,
  pdh_item_if.sink                        items,
  pdh_result_if.source                    results
);
  import pdh_pkg::*;

  localparam int AW          = $clog2(MAX_ATOMS);
  localparam int CNT_W       = $clog2(MAX_ATOMS + 1);
  localparam int KIND_W      = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
  localparam int ATOM_W      = 3 * POS_W + KIND_W;
  localparam int NUM_CLASSES = NUM_SPECIES * (NUM_SPECIES + 1) / 2;
  localparam int CLS_W       = $clog2(NUM_CLASSES + 1);
  localparam int HIST_DEPTH  = (NUM_CLASSES + 1) * MAX_BINS;
  localparam int HAW         = $clog2(HIST_DEPTH);
  localparam int BIN_BITS    = $clog2(MAX_BINS);
  localparam int NB_W        = $clog2(MAX_BINS + 1);
  localparam int CUT_W       = NB_W + BOX_W;
  localparam int ROOT_W      = 34;
  localparam int BCMP_W      = (CUT_W > ROOT_W) ? CUT_W : ROOT_W;
  localparam int WSH_W       = BOX_W + BIN_BITS;
  localparam int NK_W        = CNT_W + BINSEL_W + 1;
  localparam int DEN_W       = 2 * NK_W;
  localparam int NUM_W       = 82;
  localparam int DSH_W       = DEN_W + 31;
  localparam int CMP_W       = (DEN_W + 33 > NUM_W) ? DEN_W + 33 : NUM_W;
  localparam int STEP_W      = 6;

  typedef enum logic [24:0] {
    S_CLEAR   = 25'b1 << 0,
    S_IDLE    = 25'b1 << 1,
    S_I_RD    = 25'b1 << 2,
    S_I_LD    = 25'b1 << 3,
    S_J_RD    = 25'b1 << 4,
    S_J_LD    = 25'b1 << 5,
    S_MOD     = 25'b1 << 6,
    S_FOLD    = 25'b1 << 7,
    S_SQ      = 25'b1 << 8,
    S_SQRT    = 25'b1 << 9,
    S_BIN_CHK = 25'b1 << 10,
    S_DIV     = 25'b1 << 11,
    S_INC0_RD = 25'b1 << 12,
    S_INC0_WR = 25'b1 << 13,
    S_INCC_RD = 25'b1 << 14,
    S_INCC_WR = 25'b1 << 15,
    S_NEXT    = 25'b1 << 16,
    S_RD_DATA = 25'b1 << 17,
    S_G_NK    = 25'b1 << 18,
    S_G_DEN   = 25'b1 << 19,
    S_G_NUM0  = 25'b1 << 20,
    S_G_NUM1  = 25'b1 << 21,
    S_G_SAT   = 25'b1 << 22,
    S_G_DIV   = 25'b1 << 23,
    S_DONE    = 25'b1 << 24
  } state_t;

  // configuration registers
  logic                  pbc_enable;
  logic [BOX_W-1:0]      box_len_x, box_len_y, box_len_z;
  logic [BOX_W-1:0]      bin_width_q;
  logic [BINS_W-1:0]     bins_in_use;
  logic [CFG_DATA_W-1:0] norm_scale;
  logic                  pair_mode;

  // control state
  state_t            state;
  logic [CNT_W-1:0]  atom_count;
  logic              set_done;
  logic              overflow_flag;
  logic [COUNT_W-1:0] pair_total;
  logic [HAW-1:0]    clr;
  logic              clr_run;
  logic [AW-1:0]     i_idx, j_idx;
  logic [STEP_W-1:0] step;

  // result register
  logic               res_valid;
  logic               res_kind;
  logic [COUNT_W-1:0] res_pairs, res_g, res_total;
  logic [ATOMS_W-1:0] res_atoms;
  logic               res_ovf;
  logic               pend_kind;

  // pair datapath
  logic [2:0][POS_W-1:0] pos_i;
  logic [KIND_W-1:0]     kind_i, kind_j;
  logic [2:0][31:0]      mag, magsh, mod_rem;
  logic [65:0]           sq_sum;
  logic [67:0]           rad;
  logic [35:0]           sq_rem;
  logic [ROOT_W-1:0]     root;
  logic [CUT_W-1:0]      cutoff;
  logic [ROOT_W-1:0]     brem;
  logic [WSH_W-1:0]      wsh;
  logic [BIN_BITS-1:0]   bin_q;

  // read datapath
  logic [BINSEL_W-1:0]   rd_bin;
  logic                  rd_ok;
  logic [COUNT_W-1:0]    cnt_val;
  logic [COUNT_W-1:0]    g_val;
  logic [NK_W-1:0]       nk;
  logic [DEN_W-1:0]      den;
  logic [NUM_W-1:0]      num;
  logic [NUM_W-1:0]      grem;
  logic [DSH_W-1:0]      dsh;

  // memories
  logic              atom_we;
  logic [AW-1:0]     atom_waddr, atom_raddr;
  logic [ATOM_W-1:0] atom_wdata, atom_rdata;
  logic              hist_we;
  logic [HAW-1:0]    hist_addr;
  logic [COUNT_W-1:0] hist_wdata, hist_rdata;

  pdh_ram #(.WIDTH(ATOM_W), .DEPTH(MAX_ATOMS)) u_atom_ram (
    .clk   (clk),
    .we    (atom_we),
    .waddr (atom_waddr),
    .wdata (atom_wdata),
    .raddr (atom_raddr),
    .rdata (atom_rdata)
  );

  pdh_ram #(.WIDTH(COUNT_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_addr),
    .wdata (hist_wdata),
    .raddr (hist_addr),
    .rdata (hist_rdata)
  );

  // class of an unordered species pair, class 0 is the total histogram
  function automatic logic [CLS_W-1:0] pair_class(input logic [KIND_W-1:0] ka,
                                                  input logic [KIND_W-1:0] kb);
    logic [KIND_W-1:0] lo_k, hi_k;
    logic [15:0]       tri_v;
    lo_k  = (ka > kb) ? kb : ka;
    hi_k  = (ka > kb) ? ka : kb;
    tri_v = 16'(lo_k) * (16'(2 * NUM_SPECIES + 1) - 16'(lo_k));
    return CLS_W'(16'd1 + (tri_v >> 1) + 16'(hi_k - lo_k));
  endfunction

  // input handshake and load path
  logic               in_acc;
  logic [CNT_W-1:0]   eff_count;
  logic               atoms_full;
  logic [KIND_W-1:0]  sp_clamped;
  logic [NB_W-1:0]    nb_lim;
  logic               rd_ok_in;
  logic [HAW-1:0]     rd_addr_in;

  assign items.ready = (state == S_IDLE);
  assign in_acc      = items.valid && items.ready;
  assign eff_count   = set_done ? '0 : atom_count;
  assign atoms_full  = (eff_count >= CNT_W'(MAX_ATOMS));
  assign sp_clamped  = (32'(items.species) >= 32'(NUM_SPECIES)) ?
                       KIND_W'(NUM_SPECIES - 1) : KIND_W'(items.species);
  assign nb_lim      = (32'(bins_in_use) > 32'(MAX_BINS)) ?
                       NB_W'(MAX_BINS) : NB_W'(bins_in_use);
  assign rd_ok_in    = (32'(items.bin_select) < 32'(MAX_BINS)) &&
                       (32'(items.class_select) <= 32'(NUM_CLASSES));
  assign rd_addr_in  = HAW'(32'(items.class_select) * 32'(MAX_BINS) +
                            32'(items.bin_select));

  assign atom_we    = in_acc && (items.action == ACT_LOAD) && !atoms_full;
  assign atom_waddr = AW'(eff_count);
  assign atom_wdata = {sp_clamped, items.pos_z, items.pos_y, items.pos_x};
  assign atom_raddr = (state == S_I_RD) ? i_idx : j_idx;

  // histogram ram port: the clearing sweep, read requests and bin updates
  logic [HAW-1:0] cls_addr;
  assign cls_addr = HAW'(32'(pair_class(kind_i, kind_j)) * 32'(MAX_BINS) + 32'(bin_q));

  always_comb begin
    hist_we    = 1'b0;
    hist_wdata = hist_rdata + 1'b1;
    hist_addr  = HAW'(bin_q);
    case (state)
      S_CLEAR: begin
        hist_we    = 1'b1;
        hist_wdata = '0;
        hist_addr  = clr;
      end
      S_IDLE:    hist_addr = rd_addr_in;
      S_INC0_WR: hist_we   = 1'b1;
      S_INCC_RD: hist_addr = cls_addr;
      S_INCC_WR: begin
        hist_we   = 1'b1;
        hist_addr = cls_addr;
      end
      default: ;
    endcase
  end

  // axis differences of atom i and the fetched atom j
  logic [2:0][BOX_W-1:0] box;
  logic [2:0][31:0]      mag_in;
  logic [2:0][32:0]      mod_t;
  logic [2:0][31:0]      mod_next, fold_val;

  assign box = {box_len_z, box_len_y, box_len_x};

  always_comb begin
    logic signed [32:0] dif;
    for (int ax = 0; ax < 3; ax++) begin
      dif = $signed({pos_i[ax][31], pos_i[ax]}) -
            $signed({atom_rdata[ax*POS_W + 31], atom_rdata[ax*POS_W +: POS_W]});
      mag_in[ax]  = dif[32] ? 32'(-dif) : 32'(dif);
      // one bit of the remainder by the box length
      mod_t[ax]    = {mod_rem[ax], magsh[ax][31]};
      mod_next[ax] = (mod_t[ax] >= 33'(box[ax])) ? 32'(mod_t[ax] - 33'(box[ax])) :
                     32'(mod_t[ax]);
      // nearest image: the remainder or its complement, ties take the complement
      if (box[ax] == '0) begin
        fold_val[ax] = mag[ax];
      end else if ({mod_rem[ax], 1'b0} >= 33'(box[ax])) begin
        fold_val[ax] = 32'(box[ax]) - mod_rem[ax];
      end else begin
        fold_val[ax] = mod_rem[ax];
      end
    end
  end

  // sum of squares, one axis per cycle
  logic [63:0] sq_prod;
  logic [65:0] sq_sum_next;
  assign sq_prod     = mag[step[1:0]] * mag[step[1:0]];
  assign sq_sum_next = sq_sum + 66'(sq_prod);

  // square root digit recurrence, two radicand bits per step
  logic [37:0] sq_t, sq_trial;
  logic        sq_ge;
  assign sq_t     = {sq_rem, rad[67:66]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);

  // bin quotient, one bit per step
  logic bin_ge;
  assign bin_ge = (BCMP_W'(brem) >= BCMP_W'(wsh));

  // g normalization
  logic [33:0] cnt4;
  logic [23:0] ns_part;
  logic [57:0] g_prod;
  logic        g_ge;
  assign cnt4    = {cnt_val, 2'b00};
  assign ns_part = (state == S_G_NUM0) ? norm_scale[23:0] : norm_scale[47:24];
  assign g_prod  = cnt4 * ns_part;
  assign g_ge    = (CMP_W'(grem) >= CMP_W'(dsh));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pbc_enable  <= 1'b0;
      box_len_x   <= '0;
      box_len_y   <= '0;
      box_len_z   <= '0;
      bin_width_q <= BIN_WIDTH_RESET;
      bins_in_use <= BINS_RESET;
      norm_scale  <= '0;
      pair_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PBC_ENABLE:  pbc_enable  <= cfg_data[0];
        REG_BOX_LEN_X:   box_len_x   <= cfg_data[BOX_W-1:0];
        REG_BOX_LEN_Y:   box_len_y   <= cfg_data[BOX_W-1:0];
        REG_BOX_LEN_Z:   box_len_z   <= cfg_data[BOX_W-1:0];
        REG_BIN_WIDTH:   bin_width_q <= cfg_data[BOX_W-1:0];
        REG_BINS_IN_USE: bins_in_use <= cfg_data[BINS_W-1:0];
        REG_NORM_SCALE:  norm_scale  <= cfg_data;
        REG_PAIR_MODE:   pair_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register: a finished transaction waits here while new loads go on
  logic [31:0] cnt32;
  assign cnt32 = 32'(atom_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && (!res_valid || results.ready)) begin
      res_valid <= 1'b1;
      res_kind  <= pend_kind;
      res_pairs <= cnt_val;
      res_g     <= g_val;
      res_total <= pair_total;
      res_atoms <= cnt32[ATOMS_W-1:0];
      res_ovf   <= overflow_flag;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign results.valid         = res_valid;
  assign results.result_kind   = res_kind;
  assign results.bin_pairs     = res_pairs;
  assign results.g_value       = res_g;
  assign results.pairs_counted = res_total;
  assign results.atoms_loaded  = res_atoms;
  assign results.load_overflow = res_ovf;

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      clr_run       <= 1'b0;
      atom_count    <= '0;
      set_done      <= 1'b0;
      overflow_flag <= 1'b0;
      pair_total    <= '0;
      i_idx         <= '0;
      j_idx         <= '0;
      step          <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == HAW'(HIST_DEPTH - 1)) begin
            state <= clr_run ? S_I_RD : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            case (action_t'(items.action))
              ACT_LOAD: begin
                if (set_done) begin
                  set_done      <= 1'b0;
                  overflow_flag <= atoms_full;
                end else if (atoms_full) begin
                  overflow_flag <= 1'b1;
                end
                atom_count <= atoms_full ? eff_count : eff_count + 1'b1;
              end
              ACT_RUN: begin
                cutoff     <= CUT_W'(nb_lim) * CUT_W'(bin_width_q);
                pair_total <= '0;
                clr        <= '0;
                clr_run    <= 1'b1;
                i_idx      <= '0;
                state      <= S_CLEAR;
              end
              ACT_READ: begin
                rd_bin <= items.bin_select;
                rd_ok  <= rd_ok_in;
                state  <= S_RD_DATA;
              end
              default: ;
            endcase
          end
        end

        // pair walk
        S_I_RD: begin
          if (CNT_W'(i_idx) + 1'b1 >= atom_count) begin
            pend_kind <= RESULT_RUN;
            cnt_val   <= '0;
            g_val     <= '0;
            set_done  <= 1'b1;
            state     <= S_DONE;
          end else begin
            state <= S_I_LD;
          end
        end

        S_I_LD: begin
          pos_i  <= {atom_rdata[2*POS_W +: POS_W], atom_rdata[POS_W +: POS_W],
                     atom_rdata[0 +: POS_W]};
          kind_i <= atom_rdata[3*POS_W +: KIND_W];
          j_idx  <= i_idx + 1'b1;
          state  <= S_J_RD;
        end

        S_J_RD: state <= S_J_LD;

        S_J_LD: begin
          mag     <= mag_in;
          magsh   <= mag_in;
          mod_rem <= '0;
          kind_j  <= atom_rdata[3*POS_W +: KIND_W];
          sq_sum  <= '0;
          if (pbc_enable) begin
            step  <= STEP_W'(31);
            state <= S_MOD;
          end else begin
            step  <= '0;
            state <= S_SQ;
          end
        end

        S_MOD: begin
          mod_rem <= mod_next;
          for (int ax = 0; ax < 3; ax++) begin
            magsh[ax] <= {magsh[ax][30:0], 1'b0};
          end
          step <= step - 1'b1;
          if (step == '0) begin
            state <= S_FOLD;
          end
        end

        S_FOLD: begin
          mag   <= fold_val;
          step  <= '0;
          state <= S_SQ;
        end

        S_SQ: begin
          sq_sum <= sq_sum_next;
          if (step == STEP_W'(2)) begin
            rad    <= {2'b00, sq_sum_next};
            sq_rem <= '0;
            root   <= '0;
            step   <= STEP_W'(ROOT_W - 1);
            state  <= (bin_width_q == '0) ? S_NEXT : S_SQRT;
          end else begin
            step <= step + 1'b1;
          end
        end

        S_SQRT: begin
          rad    <= {rad[65:0], 2'b00};
          sq_rem <= sq_ge ? 36'(sq_t - sq_trial) : 36'(sq_t);
          root   <= {root[ROOT_W-2:0], sq_ge};
          step   <= step - 1'b1;
          if (step == '0) begin
            state <= S_BIN_CHK;
          end
        end

        S_BIN_CHK: begin
          brem  <= root;
          wsh   <= WSH_W'(bin_width_q) << (BIN_BITS - 1);
          bin_q <= '0;
          step  <= STEP_W'(BIN_BITS - 1);
          state <= (BCMP_W'(root) >= BCMP_W'(cutoff)) ? S_NEXT : S_DIV;
        end

        S_DIV: begin
          if (bin_ge) begin
            brem <= ROOT_W'(BCMP_W'(brem) - BCMP_W'(wsh));
          end
          bin_q <= {bin_q[BIN_BITS-2:0], bin_ge};
          wsh   <= wsh >> 1;
          step  <= step - 1'b1;
          if (step == '0) begin
            state <= S_INC0_RD;
          end
        end

        S_INC0_RD: state <= S_INC0_WR;

        S_INC0_WR: begin
          pair_total <= pair_total + 1'b1;
          state      <= pair_mode ? S_INCC_RD : S_NEXT;
        end

        S_INCC_RD: state <= S_INCC_WR;
        S_INCC_WR: state <= S_NEXT;

        S_NEXT: begin
          if (CNT_W'(j_idx) + 1'b1 < atom_count) begin
            j_idx <= j_idx + 1'b1;
            state <= S_J_RD;
          end else begin
            i_idx <= i_idx + 1'b1;
            state <= S_I_RD;
          end
        end

        // bin read and g normalization
        S_RD_DATA: begin
          cnt_val <= rd_ok ? hist_rdata : '0;
          state   <= S_G_NK;
        end

        S_G_NK: begin
          nk    <= NK_W'(atom_count) * NK_W'({rd_bin, 1'b1});
          state <= S_G_DEN;
        end

        S_G_DEN: begin
          den   <= DEN_W'(nk) * DEN_W'(nk);
          state <= S_G_NUM0;
        end

        S_G_NUM0: begin
          num   <= NUM_W'(g_prod);
          state <= S_G_NUM1;
        end

        S_G_NUM1: begin
          num   <= num + (NUM_W'(g_prod) << 24);
          state <= S_G_SAT;
        end

        S_G_SAT: begin
          pend_kind <= RESULT_READ;
          grem      <= num;
          dsh       <= {den, 31'b0};
          step      <= STEP_W'(31);
          if (atom_count == '0 || cnt_val == '0) begin
            g_val <= '0;
            state <= S_DONE;
          end else if (CMP_W'(num) >= CMP_W'({den, 32'b0})) begin
            g_val <= '1;
            state <= S_DONE;
          end else begin
            g_val <= '0;
            state <= S_G_DIV;
          end
        end

        S_G_DIV: begin
          if (g_ge) begin
            grem <= NUM_W'(CMP_W'(grem) - CMP_W'(dsh));
          end
          g_val <= {g_val[COUNT_W-2:0], g_ge};
          dsh   <= dsh >> 1;
          step  <= step - 1'b1;
          if (step == '0) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!res_valid || results.ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // histogram ram is written only by the sweep and by bin updates
  a_hist_write_src: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> (state == S_CLEAR || state == S_INC0_WR || state == S_INCC_WR))
    else $error("histogram write outside sweep or update");

  // the pair walk only ever fetches a partner above the anchor atom
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_J_RD) |-> (j_idx > i_idx))
    else $error("pair walk out of order");

  // a bin update always targets a bin below the cutoff
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_INC0_RD) |-> (32'(bin_q) < 32'(nb_lim)))
    else $error("bin update beyond bins in use");

  // a result appears only after a transaction finishes
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_DONE))
    else $error("result without a finished transaction");

  // atom count never passes the store depth
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    atom_count <= CNT_W'(MAX_ATOMS))
    else $error("atom count beyond store depth");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pair distance histogram block
// ----------------------------------------------------------------------------
// Loads small atom sets, runs the pair sweep and reads bins back. Each
// transaction is compared with an in-bench predictor that keeps its own copy
// of the atoms, histograms and registers. Covers directed corner cases,
// random phases of register settings and a full atom memory at the end.
// ----------------------------------------------------------------------------
module tb;
  import pdh_pkg::*;

  localparam int ATOM_CAP   = 1024;
  localparam int BIN_CAP    = 256;
  localparam int CLASS_CAP  = 36;
  localparam int WATCH_MAX  = 1000000;
  localparam int ITEM_GOAL  = 1750;
  localparam int SETTLE     = 200;

  typedef struct {
    action_t               act;
    logic signed [31:0]    x, y, z;
    logic [2:0]            sp;
    logic [7:0]            bin;
    logic [5:0]            cls;
  } rdf_item_t;

  typedef struct {
    logic        kind;
    logic [31:0] pairs, g, total;
    logic [10:0] atoms;
    logic        ovf;
  } rdf_answer_t;

  // predictor of the histogram block plus the queue of owed answers
  class rdf_scoreboard;
    bit signed [31:0] px[ATOM_CAP], py[ATOM_CAP], pz[ATOM_CAP];
    bit [2:0]         kind[ATOM_CAP];
    int unsigned      natoms;
    bit               set_closed, ovf;
    bit [31:0]        hist[CLASS_CAP+1][BIN_CAP];
    bit [31:0]        binned;
    bit               pbc, pmode;
    bit [30:0]        box[3];
    bit [30:0]        bw;
    bit [8:0]         nbins;
    bit [47:0]        norm;
    rdf_answer_t      owed[$];
    int               errors, checked;

    function new();
      natoms = 0; set_closed = 0; ovf = 0; binned = 0;
      pbc = 0; pmode = 0; box[0] = 0; box[1] = 0; box[2] = 0;
      bw = BIN_WIDTH_RESET; nbins = BINS_RESET; norm = 0;
      errors = 0; checked = 0;
      foreach (hist[c, b]) hist[c][b] = 0;
    endfunction

    function void set_reg(reg_index_t idx, bit [47:0] v);
      case (idx)
        REG_PBC_ENABLE:  pbc = v[0];
        REG_BOX_LEN_X:   box[0] = v[30:0];
        REG_BOX_LEN_Y:   box[1] = v[30:0];
        REG_BOX_LEN_Z:   box[2] = v[30:0];
        REG_BIN_WIDTH:   bw = v[30:0];
        REG_BINS_IN_USE: nbins = v[8:0];
        REG_NORM_SCALE:  norm = v;
        REG_PAIR_MODE:   pmode = v[0];
        default: ;
      endcase
    endfunction

    // axis separation folded into the nearest image, rounding half away
    function bit [63:0] fold(longint d, bit [30:0] len);
      bit [63:0] m, l, q, s;
      m = (d < 0) ? -d : d;
      if (pbc && len != 0) begin
        l = len;
        q = (2 * m + l) / (2 * l);
        s = q * l;
        m = (s > m) ? s - m : m - s;
      end
      return m;
    endfunction

    function bit [33:0] root(bit [127:0] v);
      bit [127:0] t;
      bit [33:0]  s;
      s = 0;
      for (int b = 33; b >= 0; b--) begin
        t = s | (34'd1 << b);
        if (t * t <= v) s = t[33:0];
      end
      return s;
    endfunction

    function int unsigned class_of(int unsigned a, int unsigned b);
      int unsigned t;
      if (a > b) begin
        t = a; a = b; b = t;
      end
      return 1 + a * (17 - a) / 2 + (b - a);
    endfunction

    function void sweep();
      int unsigned lim;
      bit [127:0]  mx, my, mz, sq;
      bit [63:0]   bin;
      lim = (nbins > BIN_CAP) ? BIN_CAP : nbins;
      foreach (hist[c, b]) hist[c][b] = 0;
      binned = 0;
      for (int i = 0; i < natoms; i++) begin
        for (int j = i + 1; j < natoms; j++) begin
          mx = fold(longint'(px[i]) - longint'(px[j]), box[0]);
          my = fold(longint'(py[i]) - longint'(py[j]), box[1]);
          mz = fold(longint'(pz[i]) - longint'(pz[j]), box[2]);
          sq = mx * mx + my * my + mz * mz;
          if (bw == 0) continue;
          bin = root(sq) / bw;
          if (bin >= lim) continue;
          hist[0][bin]++;
          binned++;
          if (pmode) hist[class_of(kind[i], kind[j])][bin]++;
        end
      end
    endfunction

    function bit [31:0] g_norm(bit [31:0] c, int unsigned b);
      bit [127:0] den, num, q;
      if (natoms == 0 || c == 0) return 0;
      den = natoms * natoms;
      den = den * (2 * b + 1) * (2 * b + 1);
      num = 128'(c) * 4 * norm;
      q = num / den;
      if (q > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return q[31:0];
    endfunction

    function void note_input(rdf_item_t it);
      rdf_answer_t a;
      a.kind = RESULT_RUN; a.pairs = 0; a.g = 0;
      case (it.act)
        ACT_LOAD: begin
          if (set_closed) begin
            natoms = 0; ovf = 0; set_closed = 0;
          end
          if (natoms >= ATOM_CAP) ovf = 1;
          else begin
            px[natoms] = it.x; py[natoms] = it.y; pz[natoms] = it.z;
            kind[natoms] = it.sp;
            natoms++;
          end
          return;
        end
        ACT_RUN: begin
          sweep();
          set_closed = 1;
        end
        ACT_READ: begin
          a.kind = RESULT_READ;
          if (it.cls <= CLASS_CAP) begin
            a.pairs = hist[it.cls][it.bin];
            a.g = g_norm(a.pairs, it.bin);
          end
        end
        default: return;
      endcase
      a.total = binned;
      a.atoms = natoms[10:0];
      a.ovf = ovf;
      owed = {owed, a};
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("error: %s got %0h expected %0h (answer %0d)", what, got, want, checked);
      errors++;
    endtask

    task check_result(rdf_answer_t r);
      rdf_answer_t e;
      if (owed.size() == 0) begin
        report("unexpected answer, kind", r.kind, 0);
        return;
      end
      e = owed.pop_front();
      if (r.kind !== e.kind) report("result_kind", r.kind, e.kind);
      if (r.pairs !== e.pairs) report("bin_pairs", r.pairs, e.pairs);
      if (r.g !== e.g) report("g_value", r.g, e.g);
      if (r.total !== e.total) report("pairs_counted", r.total, e.total);
      if (r.atoms !== e.atoms) report("atoms_loaded", r.atoms, e.atoms);
      if (r.ovf !== e.ovf) report("load_overflow", r.ovf, e.ovf);
      checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pdh_item_if   items();
  pdh_result_if results();

  pair_distance_histogram_rdf dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results)
  );

  rdf_scoreboard sb;
  bit            calm;        // no idling on either side while set
  int            quiet_cycles;
  int            n_load, n_run, n_read, n_phase;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // sink side back-pressure, ready low about 13 percent of the time when not calm
  always @(negedge clk) begin
    results.ready <= calm || ($urandom_range(0, 99) >= 13);
  end

  // accept monitor, predictor feed and the stall watchdog
  always @(posedge clk) begin
    rdf_item_t   it;
    rdf_answer_t r;
    bit          busy;
    if (!rst) begin
      busy = 1'b0;
      if (items.valid && items.ready) begin
        it.act = action_t'(items.action);
        it.x = items.pos_x; it.y = items.pos_y; it.z = items.pos_z;
        it.sp = items.species; it.bin = items.bin_select; it.cls = items.class_select;
        sb.note_input(it);
        busy = 1'b1;
      end
      if (results.valid && results.ready) begin
        r.kind = results.result_kind; r.pairs = results.bin_pairs;
        r.g = results.g_value; r.total = results.pairs_counted;
        r.atoms = results.atoms_loaded; r.ovf = results.load_overflow;
        sb.check_result(r);
        busy = 1'b1;
      end
      quiet_cycles <= busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCH_MAX) begin
        $display("timeout: no transaction for %0d cycles", WATCH_MAX);
        $display("pair_distance_histogram_rdf: mismatch");
        $finish;
      end
    end
  end

  // one transaction on the item channel; valid stays up for the next one
  task automatic send(rdf_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 13) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid <= 1'b1;
    items.action <= it.act;
    items.pos_x <= it.x; items.pos_y <= it.y; items.pos_z <= it.z;
    items.species <= it.sp;
    items.bin_select <= it.bin;
    items.class_select <= it.cls;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    case (it.act)
      ACT_LOAD: n_load++;
      ACT_RUN:  n_run++;
      ACT_READ: n_read++;
      default: ;
    endcase
  endtask

  task automatic load_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [2:0] sp);
    rdf_item_t it;
    it.act = ACT_LOAD; it.x = x; it.y = y; it.z = z; it.sp = sp;
    it.bin = 8'($urandom); it.cls = 6'($urandom);
    send(it);
  endtask

  task automatic command(action_t a, logic [7:0] bin, logic [5:0] cls);
    rdf_item_t it;
    it.act = a; it.x = $urandom; it.y = $urandom; it.z = $urandom;
    it.sp = 3'($urandom);
    it.bin = bin; it.cls = cls;
    send(it);
  endtask

  // wait for every owed answer, then let the block settle
  task automatic drain();
    @(negedge clk);
    items.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [47:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [47:0] pick_box();
    case ($urandom_range(0, 5))
      0: return 48'd0;
      1: return 48'h7FFF_FFFF;
      default: return 48'($urandom_range(1 << 20, 1 << 24));
    endcase
  endfunction

  function automatic logic [31:0] rand_pos(int spread);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return ($urandom & ((1 << spread) - 1)) - (1 << (spread - 1));
  endfunction

  task automatic random_config();
    logic [47:0] v;
    write_reg(REG_PBC_ENABLE, 48'($urandom_range(0, 1)));
    write_reg(REG_BOX_LEN_X, pick_box());
    write_reg(REG_BOX_LEN_Y, pick_box());
    write_reg(REG_BOX_LEN_Z, pick_box());
    case ($urandom_range(0, 9))
      0: v = 48'd1;
      1: v = 48'h7FFF_FFFF;
      default: v = 48'($urandom_range(1 << 14, 1 << 17));
    endcase
    write_reg(REG_BIN_WIDTH, v);
    v = ($urandom_range(0, 7) == 0) ? 48'($urandom_range(257, 511)) :
                                      48'($urandom_range(1, 256));
    write_reg(REG_BINS_IN_USE, v);
    case ($urandom_range(0, 3))
      0: v = 48'hFFFF_FFFF_FFFF;
      1: v = 48'($urandom_range(0, 1 << 20));
      default: v = 48'({$urandom, $urandom});
    endcase
    write_reg(REG_NORM_SCALE, v);
    write_reg(REG_PAIR_MODE, 48'($urandom_range(0, 1)));
  endtask

  // one atom set: loads, the sweep, then bin reads; some sets are broken
  task automatic random_set();
    int          n, spread, nreads;
    logic [7:0]  bin;
    logic [5:0]  cls;
    n = ($urandom_range(0, 14) == 0) ? $urandom_range(13, 30) : $urandom_range(2, 12);
    spread = $urandom_range(14, 24);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) command(ACT_SPARE, 8'($urandom), 6'($urandom));
      load_atom(rand_pos(spread), rand_pos(spread), rand_pos(spread), 3'($urandom));
      // stale read in the middle of a set
      if ($urandom_range(0, 39) == 0) command(ACT_READ, 8'($urandom_range(0, 15)), 6'd0);
    end
    // an unswept set carries over into the next one, but only while it holds at most 30 atoms
    if ($urandom_range(0, 9) != 0 || sb.natoms > 30) begin
      command(ACT_RUN, 8'($urandom), 6'($urandom));
    end
    nreads = $urandom_range(6, 20);
    for (int i = 0; i < nreads; i++) begin
      bin = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                          8'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cls = 6'd0;
        4:          cls = 6'($urandom_range(37, 63));
        default:    cls = 6'($urandom_range(1, 36));
      endcase
      command(ACT_READ, bin, cls);
    end
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    quiet_cycles = 0;
    n_load = 0; n_run = 0; n_read = 0; n_phase = 0;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = REG_PBC_ENABLE; cfg_data = '0;
    items.valid = 1'b0; items.action = ACT_LOAD;
    items.pos_x = '0; items.pos_y = '0; items.pos_z = '0;
    items.species = '0; items.bin_select = '0; items.class_select = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed corner cases ----
    // read before any atom exists gives zero g, the spare action is dropped
    command(ACT_READ, 0, 0);
    command(ACT_SPARE, 8'hFF, 6'h3F);
    drain();
    // periodic with one zero-length axis, half-box separation, excess bins
    write_reg(REG_PBC_ENABLE, 1);
    write_reg(REG_BOX_LEN_X, 0);
    write_reg(REG_BOX_LEN_Y, 48'd655360);
    write_reg(REG_BOX_LEN_Z, 48'h7FFF_FFFF);
    write_reg(REG_BIN_WIDTH, 48'd65536);
    write_reg(REG_BINS_IN_USE, 511);
    write_reg(REG_NORM_SCALE, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_PAIR_MODE, 1);
    load_atom(0, 0, 0, 0);
    load_atom(0, 32'd327680, 0, 7);
    load_atom(32'h7FFF_FFFF, 32'h8000_0000, 0, 3);
    load_atom(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3);
    command(ACT_RUN, 0, 0);
    command(ACT_READ, 0, 0);        // saturating g
    command(ACT_READ, 5, 8);
    command(ACT_READ, 255, 36);
    command(ACT_READ, 0, 37);       // class beyond the table
    command(ACT_READ, 0, 63);
    // a new set after the sweep, read against the old counts
    load_atom(32'h0001_0000, 0, 0, 1);
    load_atom(0, 32'h0001_0000, 0, 2);
    command(ACT_READ, 0, 0);
    drain();
    // zero bin width bins nothing
    write_reg(REG_BIN_WIDTH, 0);
    command(ACT_RUN, 0, 0);
    command(ACT_READ, 0, 0);
    drain();
    // zero bins bins nothing either
    write_reg(REG_BIN_WIDTH, 1);
    write_reg(REG_BINS_IN_USE, 0);
    command(ACT_RUN, 0, 0);
    drain();

    // ---- random phases; one phase runs with no idling at all ----
    // the full memory phase at the end takes the rest of the item budget
    while (n_load + n_run + n_read < ITEM_GOAL - ATOM_CAP - 3) begin
      random_config();
      calm = (n_phase == 2);
      for (int s = 0; s < 4; s++) random_set();
      // hold the sender until every answer is back
      drain();
      calm = 1'b0;
      n_phase++;
    end

    // ---- full atom memory: loads past the limit are dropped ----
    write_reg(REG_NORM_SCALE, 48'h0000_0100_0000);
    for (int i = 0; i <= ATOM_CAP; i++) load_atom($urandom, $urandom, $urandom, 3'($urandom));
    command(ACT_READ, 0, 0);
    command(ACT_READ, 3, 40);
    drain();

    repeat (SETTLE) @(posedge clk);
    $display("covered %0d loads, %0d sweeps, %0d bin reads over %0d random phases",
             n_load, n_run, n_read, n_phase);
    $display("%0d answers checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("pair_distance_histogram_rdf: match");
    end else begin
      $display("pair_distance_histogram_rdf: mismatch");
    end
    $finish;
  end

endmodule
